/* design/lwmc_pkg.sv */
// lwmc_pkg: shared constants and types of the lz window match copier
// no dependencies; used by every module of the block
`default_nettype none

package lwmc_pkg;

   // default sizes of the window store and of the longest match
   localparam int WindowDepthDefault = 65536;
   localparam int MaxMatchDefault    = 64;

   // fixed field widths of the stream and register ports
   localparam int SizeW = 17;
   localparam int LenW  = 7;
   localparam int DistW = 17;

   // window size after reset
   localparam logic [SizeW-1:0] SizeReset = 17'h10000;

   // command codes carried in the request tuser
   typedef enum logic {
      CmdLiteral = 1'b0,
      CmdMatch   = 1'b1
   } cmd_type;

   // one byte slot travelling from the sequencer into the write stage
   typedef struct packed {
      logic       valid;
      logic       mem_rd;
      logic       zero;
      logic       wr;
      logic       byte_valid;
      logic       status;
      logic       last;
      logic [7:0] lit;
   } issue_type;

   // one result as held in the output queue
   typedef struct packed {
      logic       last;
      logic       status;
      logic       byte_valid;
      logic [7:0] data;
   } result_type;

endpackage

`default_nettype wire

/* design/lwmc_seq.sv */
// lwmc_seq: command decode, window bounds checks and per-byte issue sequencer
// depends on lwmc_pkg
`default_nettype none

module lwmc_seq #(
   parameter int WINDOW_DEPTH = lwmc_pkg::WindowDepthDefault,
   parameter int MAX_MATCH    = lwmc_pkg::MaxMatchDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [lwmc_pkg::SizeW-1:0]      csr_wr_data,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_command,
   input  wire logic [7:0]                      req_literal,
   input  wire logic [lwmc_pkg::LenW-1:0]       req_length,
   input  wire logic [lwmc_pkg::DistW-1:0]      req_distance,
   input  wire logic                            issue_ok,
   output lwmc_pkg::issue_type                  issue,
   output logic [$clog2(WINDOW_DEPTH)-1:0]      rd_addr,
   output logic [$clog2(WINDOW_DEPTH)-1:0]      wr_addr,
   output logic                                 busy
);

   localparam int AW = $clog2(WINDOW_DEPTH);
   localparam int PW = $clog2(WINDOW_DEPTH + 1);
   localparam int CW = ((PW > lwmc_pkg::SizeW) ? PW : lwmc_pkg::SizeW) + 1;

   logic [lwmc_pkg::SizeW-1:0] size_ff, size_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic                       busy_ff, busy_in;
   logic                       zero_ff, zero_in;
   logic [lwmc_pkg::LenW-1:0]  remain_ff, remain_in;
   logic [AW-1:0]              src_ff, src_in;
   logic [AW-1:0]              dst_ff, dst_in;

   logic          accept;
   logic          is_match;
   logic [CW-1:0] size_w;
   logic [CW-1:0] usable_w;
   logic [CW-1:0] pos_w;
   logic [CW-1:0] dist_w;
   logic [CW-1:0] end_w;
   logic          lit_reject;
   logic          match_reject;
   logic          match_empty;
   logic          match_zero_fill;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff && issue_ok;
   assign busy      = busy_ff;
   assign is_match  = (req_command == lwmc_pkg::CmdMatch);

   // bounds checks against the usable window size
   always_comb begin
      size_w          = CW'(size_ff);
      usable_w        = (size_w > CW'(WINDOW_DEPTH)) ? CW'(WINDOW_DEPTH) : size_w;
      pos_w           = CW'(pos_ff);
      dist_w          = CW'(req_distance);
      end_w           = pos_w + CW'(req_length);
      lit_reject      = (pos_w >= usable_w);
      match_reject    = (req_length > lwmc_pkg::LenW'(MAX_MATCH)) || (end_w > usable_w);
      match_empty     = (req_length == '0);
      match_zero_fill = (req_distance == '0) || (dist_w > pos_w);
   end

   // issue slot toward the write stage
   always_comb begin
      issue   = '0;
      rd_addr = src_ff;
      wr_addr = dst_ff;
      if (busy_ff) begin
         if (issue_ok) begin
            issue.valid      = 1'b1;
            issue.mem_rd     = !zero_ff;
            issue.zero       = zero_ff;
            issue.wr         = 1'b1;
            issue.byte_valid = 1'b1;
            issue.last       = (remain_ff == lwmc_pkg::LenW'(1));
         end
      end else if (accept) begin
         wr_addr = pos_ff[AW-1:0];
         if (!is_match) begin
            issue.valid = 1'b1;
            issue.last  = 1'b1;
            if (lit_reject) begin
               issue.status = 1'b1;
            end else begin
               issue.wr         = 1'b1;
               issue.byte_valid = 1'b1;
               issue.lit        = req_literal;
            end
         end else if (match_reject || match_empty) begin
            issue.valid  = 1'b1;
            issue.last   = 1'b1;
            issue.status = match_reject;
         end
      end
   end

   // next state of the position and the match walker
   always_comb begin
      size_in   = size_ff;
      pos_in    = pos_ff;
      busy_in   = busy_ff;
      zero_in   = zero_ff;
      remain_in = remain_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      priority if (csr_wr_en) begin
         size_in = csr_wr_data;
         pos_in  = '0;
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (issue_ok) begin
            src_in    = src_ff + AW'(1);
            dst_in    = dst_ff + AW'(1);
            remain_in = remain_ff - lwmc_pkg::LenW'(1);
            if (remain_ff == lwmc_pkg::LenW'(1)) begin
               busy_in = 1'b0;
            end
         end
      end else if (accept) begin
         if (!is_match) begin
            if (!lit_reject) begin
               pos_in = pos_ff + PW'(1);
            end
         end else if (!match_reject && !match_empty) begin
            busy_in   = 1'b1;
            zero_in   = match_zero_fill;
            remain_in = req_length;
            src_in    = AW'(pos_w - dist_w);
            dst_in    = pos_ff[AW-1:0];
            pos_in    = PW'(end_w);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= lwmc_pkg::SizeReset;
         pos_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         size_ff <= size_in;
         pos_ff  <= pos_in;
         busy_ff <= busy_in;
      end
      zero_ff   <= zero_in;
      remain_ff <= remain_in;
      src_ff    <= src_in;
      dst_ff    <= dst_in;
   end

endmodule

`default_nettype wire

/* design/lwmc_win.sv */
// lwmc_win: window store with one read and one write port, plus the write stage
// depends on lwmc_pkg; fed by lwmc_seq
`default_nettype none

module lwmc_win #(
   parameter int WINDOW_DEPTH = lwmc_pkg::WindowDepthDefault
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lwmc_pkg::issue_type             issue,
   input  wire logic [$clog2(WINDOW_DEPTH)-1:0] rd_addr,
   input  wire logic [$clog2(WINDOW_DEPTH)-1:0] wr_addr,
   output logic                                 push,
   output lwmc_pkg::result_type                 push_data
);

   localparam int AW = $clog2(WINDOW_DEPTH);

   logic [7:0] mem [WINDOW_DEPTH];

   lwmc_pkg::issue_type b_ff;
   logic [AW-1:0]       b_addr_ff;
   logic [7:0]          rd_data_ff;
   logic                byp_ff, byp_in;
   logic [7:0]          byp_data_ff;
   logic [7:0]          b_byte;
   logic                b_write;

   // byte of the write stage: copied, forwarded, zero or literal
   always_comb begin
      priority if (b_ff.mem_rd) begin
         b_byte = byp_ff ? byp_data_ff : rd_data_ff;
      end else if (b_ff.zero) begin
         b_byte = '0;
      end else begin
         b_byte = b_ff.lit;
      end
   end

   assign b_write = b_ff.valid && b_ff.wr;

   // a read of the entry being written this cycle takes the new byte
   assign byp_in = b_write && (b_addr_ff == rd_addr);

   // memory read port
   always_ff @(posedge clock) begin
      if (issue.valid && issue.mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (b_write) begin
         mem[b_addr_ff] <= b_byte;
      end
   end

   // write stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff <= '0;
      end else begin
         b_ff <= issue;
      end
      b_addr_ff   <= wr_addr;
      byp_ff      <= byp_in;
      byp_data_ff <= b_byte;
   end

   // result toward the output queue
   assign push                 = b_ff.valid;
   assign push_data.last       = b_ff.last;
   assign push_data.status     = b_ff.status;
   assign push_data.byte_valid = b_ff.byte_valid;
   assign push_data.data       = b_byte;

endmodule

`default_nettype wire

/* design/lwmc_outq.sv */
// lwmc_outq: two-entry result queue that decouples the write stage from rsp stalls
// depends on lwmc_pkg
`default_nettype none

module lwmc_outq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire lwmc_pkg::result_type push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output lwmc_pkg::result_type      pop_data,
   output logic                      issue_ok,
   output logic [1:0]                count
);

   lwmc_pkg::result_type ent_ff [2];
   logic                 rd_ptr_ff, rd_ptr_in;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 pop;
   logic [2:0]           occ;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = ent_ff[rd_ptr_ff];
   assign count     = count_ff;

   // room for one more slot issued now, counting the one in the write stage
   assign occ      = 3'(count_ff) + 3'(push) - 3'(pop);
   assign issue_ok = (occ < 3'd2);

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = 2'(occ);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* design/lz_window_match_copier.sv */
// lz_window_match_copier: top level of the lz77 output window with match copy
// depends on lwmc_pkg, lwmc_seq, lwmc_win and lwmc_outq
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: literal_byte, match_length, match_distance
//                                       tuser: command
//   rsp      out  rsp_tvalid/tready     tdata: out_byte; tuser: byte_valid, status; tlast
//   csr      in   csr_wr_en             csr_wr_data: window_size
//
// a literal, a rejected item or a zero-length match is issued as it is accepted; a
// match of n bytes is accepted, then issued one byte per cycle while the result queue
// has room, through the single read port and single write port of the window store.
// reset clears the position, the window size, the busy flag, the write stage and the
// result queue; window bytes are undefined until written and need no clearing pass.
// rsp stalls back up through a two-entry result queue into the byte sequencer.
`default_nettype none

module lz_window_match_copier #(
   parameter int WINDOW_DEPTH = lwmc_pkg::WindowDepthDefault,
   parameter int MAX_MATCH    = lwmc_pkg::MaxMatchDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data,   // window_size
   // command stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,     // literal_byte[7:0], match_length[14:8],
                                           // match_distance[31:15]
   input  wire logic [0:0]  req_tuser,     // command[0]
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,     // out_byte[7:0]
   output logic [1:0]       rsp_tuser,     // byte_valid[0], status[1]
   output logic             rsp_tlast
);

   localparam int AW = $clog2(WINDOW_DEPTH);

   lwmc_pkg::issue_type  issue;
   lwmc_pkg::result_type push_data;
   lwmc_pkg::result_type pop_data;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        wr_addr;
   logic                 issue_ok;
   logic                 push;
   logic                 busy;
   logic [1:0]           q_count;

   // command decode and byte sequencer
   lwmc_seq #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .MAX_MATCH    (MAX_MATCH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_command  (req_tuser[0]),
      .req_literal  (req_tdata[7:0]),
      .req_length   (req_tdata[14:8]),
      .req_distance (req_tdata[31:15]),
      .issue_ok     (issue_ok),
      .issue        (issue),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .busy         (busy)
   );

   // window store and write stage
   lwmc_win #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_win (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .push      (push),
      .push_data (push_data)
   );

   // result queue
   lwmc_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_valid (rsp_tvalid),
      .pop_ready (rsp_tready),
      .pop_data  (pop_data),
      .issue_ok  (issue_ok),
      .count     (q_count)
   );

   assign rsp_tdata    = pop_data.data;
   assign rsp_tuser[0] = pop_data.byte_valid;
   assign rsp_tuser[1] = pop_data.status;
   assign rsp_tlast    = pop_data.last;

`ifndef SYNTH
   // the queue receives a transfer while full only when an entry leaves in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (push && (q_count == 2'd2)) |-> (rsp_tvalid && rsp_tready))
      else $error("result queue overflow");

   // no new command is taken while a match is still being copied
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !req_tready)
      else $error("command accepted during match copy");

   // a result without a byte always closes its item
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tlast)
      else $error("status-only result without last");

   // an accepted item reaches the write stage in the next cycle unless it opens a match
   assert property (@(posedge clock) disable iff (reset)
      (issue.valid && !busy) |=> push)
      else $error("issued slot lost before write stage");
`endif

endmodule

`default_nettype wire
